// ===== design/tensor_axis_swap_address_gen_unit_assert.svh =====
// Assertion macros shared by the tensor axis swap address generator modules.
`ifndef TENSOR_AXIS_SWAP_ADDRESS_GEN_UNIT_ASSERT_SVH
`define TENSOR_AXIS_SWAP_ADDRESS_GEN_UNIT_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define TASAG_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Condition that must hold in the cycle after a trigger, outside reset.
`define TASAG_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== design/tasag_pkg.sv =====
// Shared constants, types and helper functions of the tensor axis swap address generator.
package tasag_pkg;

   localparam int ADDR_BITS    = 20;
   localparam int DATA_BITS    = 32;
   localparam int CNT_W        = 20;
   localparam int DIM_W        = 21;
   localparam int NUM_DIMS     = 5;
   localparam int NUM_LEVELS   = 4;
   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 32;
   localparam int BUSY_W       = 3;
   localparam int PROD_W       = ADDR_BITS + DIM_W;

   localparam logic [DIM_W-1:0]  DIM_MAX       = DIM_W'(1 << CNT_W);
   localparam logic [BUSY_W-1:0] STRIDE_SETTLE = BUSY_W'(4);

   typedef enum logic [2:0] {
      REG_DIM_INNER       = 3'd0,
      REG_DIM_SWAP_FIRST  = 3'd1,
      REG_DIM_BETWEEN     = 3'd2,
      REG_DIM_SWAP_SECOND = 3'd3,
      REG_DIM_OUTER       = 3'd4
   } reg_idx_type;

   typedef logic [CNT_W-1:0]     cnt_type;
   typedef logic [ADDR_BITS-1:0] addr_type;
   typedef logic [DIM_W-1:0]     dim_type;

   typedef struct packed {
      logic [DATA_BITS-1:0] value;
      addr_type             addr;
      logic                 last;
   } beat_type;

   typedef struct packed {
      addr_type [NUM_LEVELS-1:0] stride;
      cnt_type  [NUM_DIMS-1:0]   lim;
   } walk_cfg_type;

   // Zero counts as one, anything above the largest size is clamped to it.
   function automatic dim_type eff_dim(input dim_type d);
      dim_type r;
      if (d == '0) begin
         r = dim_type'(1);
      end else if (d > DIM_MAX) begin
         r = DIM_MAX;
      end else begin
         r = d;
      end
      return r;
   endfunction

endpackage

// ===== design/tasag_skid.sv =====
// Output register with a skid stage for the result channel.
`include "tensor_axis_swap_address_gen_unit_assert.svh"

module tasag_skid import tasag_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_room,
   input  beat_type in_beat,
   output logic     out_valid,
   input  logic     out_ready,
   output beat_type out_beat
);

   logic     out_valid_ff, out_valid_in;
   logic     skid_valid_ff, skid_valid_in;
   beat_type out_beat_ff, out_beat_in;
   beat_type skid_beat_ff, skid_beat_in;
   logic     out_fire;

   assign out_fire  = out_valid_ff & out_ready;
   assign in_room   = ~skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_beat  = out_beat_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_beat_in   = out_beat_ff;
      skid_beat_in  = skid_beat_ff;
      if (!out_valid_ff || out_fire) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_beat_in   = skid_beat_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_beat_in  = in_beat;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_beat_in  = in_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_beat_ff  <= out_beat_in;
      skid_beat_ff <= skid_beat_in;
   end

   `TASAG_ASSERT(a_skid_behind_out, clock, reset, skid_valid_ff |-> out_valid_ff, "skid beat without output beat")
   `TASAG_ASSERT_NEXT(a_stall_fills_skid, clock, reset, out_valid_ff && !out_ready && in_valid, skid_valid_ff, "stalled beat not parked in skid")
   `TASAG_ASSERT_NEXT(a_skid_drains, clock, reset, skid_valid_ff && out_ready, out_valid_ff && !skid_valid_ff, "skid beat not moved forward")

endmodule

// ===== design/tasag_walk.sv =====
// Index counters and running base addresses that walk the source tensor.
`include "tensor_axis_swap_address_gen_unit_assert.svh"

module tasag_walk import tasag_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         clear,
   input  logic         step,
   input  walk_cfg_type cfg,
   output addr_type     cur_addr,
   output logic         cur_last
);

   cnt_type  [NUM_DIMS-1:0]   cnt_ff, cnt_in;
   addr_type [NUM_LEVELS-1:0] base_ff, base_in;
   addr_type                  ptr_ff, ptr_in;
   logic     [NUM_DIMS-1:0]   wrap;
   addr_type                  sum0, sum1, sum2, sum3;

   always_comb begin
      for (int k = 0; k < NUM_DIMS; k++) begin
         wrap[k] = cnt_ff[k] >= cfg.lim[k];
      end
   end

   assign cur_addr = ptr_ff;
   assign cur_last = &wrap;

   // Level 3 follows the first swapped axis, level 0 the outer axis.
   assign sum3 = base_ff[3] + cfg.stride[2];
   assign sum2 = base_ff[2] + cfg.stride[1];
   assign sum1 = base_ff[1] + cfg.stride[0];
   assign sum0 = base_ff[0] + cfg.stride[3];

   always_comb begin
      cnt_in  = cnt_ff;
      base_in = base_ff;
      ptr_in  = ptr_ff;
      if (clear) begin
         cnt_in  = '0;
         base_in = '0;
         ptr_in  = '0;
      end else if (step) begin
         if (!wrap[0]) begin
            cnt_in[0] = cnt_ff[0] + cnt_type'(1);
            ptr_in    = ptr_ff + addr_type'(1);
         end else if (!wrap[1]) begin
            cnt_in[0]  = '0;
            cnt_in[1]  = cnt_ff[1] + cnt_type'(1);
            base_in[3] = sum3;
            ptr_in     = sum3;
         end else if (!wrap[2]) begin
            cnt_in[1:0] = '0;
            cnt_in[2]   = cnt_ff[2] + cnt_type'(1);
            base_in[2]  = sum2;
            base_in[3]  = sum2;
            ptr_in      = sum2;
         end else if (!wrap[3]) begin
            cnt_in[2:0] = '0;
            cnt_in[3]   = cnt_ff[3] + cnt_type'(1);
            base_in[1]  = sum1;
            base_in[2]  = sum1;
            base_in[3]  = sum1;
            ptr_in      = sum1;
         end else if (!wrap[4]) begin
            cnt_in[3:0] = '0;
            cnt_in[4]   = cnt_ff[4] + cnt_type'(1);
            base_in[0]  = sum0;
            base_in[1]  = sum0;
            base_in[2]  = sum0;
            base_in[3]  = sum0;
            ptr_in      = sum0;
         end else begin
            cnt_in  = '0;
            base_in = '0;
            ptr_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         base_ff <= '0;
         ptr_ff  <= '0;
      end else begin
         cnt_ff  <= cnt_in;
         base_ff <= base_in;
         ptr_ff  <= ptr_in;
      end
   end

   `TASAG_ASSERT(a_cnt_in_range, clock, reset, cnt_ff[0] <= cfg.lim[0] && cnt_ff[1] <= cfg.lim[1] && cnt_ff[2] <= cfg.lim[2] && cnt_ff[3] <= cfg.lim[3] && cnt_ff[4] <= cfg.lim[4], "index counter beyond its limit")
   `TASAG_ASSERT(a_origin_addr, clock, reset, (cnt_ff == '0) |-> (ptr_ff == '0 && base_ff == '0), "first element does not start at address zero")
   `TASAG_ASSERT_NEXT(a_clear_restarts, clock, reset, clear, cnt_ff == '0 && ptr_ff == '0, "register write did not restart the walk")

endmodule

// ===== design/tensor_axis_swap_address_gen_unit.sv =====
// Top level of the tensor axis swap address generator: registers, strides and channels.
//
// The block takes source tensor elements in source storage order (inner index fastest)
// and returns each one with its offset in a destination tensor whose swap_first and
// swap_second axes are exchanged; rsp_last_elem marks the final element, after which the
// walk starts over at address zero. Addresses wrap modulo 2^20. An element is accepted on
// req_ when a result slot is free and the strides are settled, and is registered toward
// rsp_, so the sustained rate is one beat per clock while neither holds req_ready low; the
// output register plus a one-beat skid stage let the block keep taking one more element
// while a result is stalled. The five dimension registers sit at byte addresses 0, 4, 8,
// 12 and 16 (inner, swap_first, between, swap_second, outer); of the low 21 bits kept, a
// zero is taken as one and values above 2^20 as 2^20. Each write to one of them restarts
// the traversal and recomputes the four strides through a chain of registered multipliers,
// holding req_ready low while that chain settles. Writes to any other address are ignored
// and leave the walk where it was. Writes belong between tensors, with no beat in flight.

module tensor_axis_swap_address_gen_unit import tasag_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [DATA_BITS-1:0]  req_elem_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DATA_BITS-1:0]  rsp_out_value,
   output logic [ADDR_BITS-1:0]  rsp_dest_address,
   output logic                  rsp_last_elem,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   dim_type     dim_ff [NUM_DIMS];
   dim_type     dim_in [NUM_DIMS];
   addr_type    stride_ff [NUM_LEVELS];
   addr_type    stride_in [NUM_LEVELS];
   cnt_type     lim_ff [NUM_DIMS];
   cnt_type     lim_in [NUM_DIMS];
   logic [BUSY_W-1:0] busy_ff, busy_in;

   logic         cfg_wr;
   logic         cfg_hit;
   reg_idx_type  reg_idx;
   dim_type      wr_dim;
   logic [PROD_W-1:0] prod1, prod2, prod3;
   walk_cfg_type walk_cfg;
   logic         room;
   logic         accept;
   addr_type     cur_addr;
   logic         cur_last;
   beat_type     new_beat;
   beat_type     rsp_beat;

   // Register port: pready is tied high, so a write lands on the access cycle.
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx    = reg_idx_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_dim     = csr_pwdata[DIM_W-1:0];

   // Only a write that lands on a dimension register restarts the walk.
   assign cfg_hit = cfg_wr & (reg_idx inside {REG_DIM_INNER, REG_DIM_SWAP_FIRST,
                                              REG_DIM_BETWEEN, REG_DIM_SWAP_SECOND,
                                              REG_DIM_OUTER});

   always_comb begin
      for (int k = 0; k < NUM_DIMS; k++) begin
         dim_in[k] = dim_ff[k];
      end
      if (cfg_wr) begin
         case (reg_idx)
            REG_DIM_INNER:       dim_in[0] = wr_dim;
            REG_DIM_SWAP_FIRST:  dim_in[1] = wr_dim;
            REG_DIM_BETWEEN:     dim_in[2] = wr_dim;
            REG_DIM_SWAP_SECOND: dim_in[3] = wr_dim;
            REG_DIM_OUTER:       dim_in[4] = wr_dim;
            default:             dim_in[0] = dim_ff[0];
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_DIM_INNER:       csr_prdata = CSR_DATA_W'(dim_ff[0]);
         REG_DIM_SWAP_FIRST:  csr_prdata = CSR_DATA_W'(dim_ff[1]);
         REG_DIM_BETWEEN:     csr_prdata = CSR_DATA_W'(dim_ff[2]);
         REG_DIM_SWAP_SECOND: csr_prdata = CSR_DATA_W'(dim_ff[3]);
         REG_DIM_OUTER:       csr_prdata = CSR_DATA_W'(dim_ff[4]);
         default:             csr_prdata = '0;
      endcase
   end

   // The destination axis order is inner, swap_second, between, swap_first, outer, so each
   // stride is the previous one times the next destination dimension. One multiplier per
   // register stage; the chain is correct once each stride register in turn has taken its product.
   assign prod1 = PROD_W'(stride_ff[0]) * PROD_W'(eff_dim(dim_ff[3]));
   assign prod2 = PROD_W'(stride_ff[1]) * PROD_W'(eff_dim(dim_ff[2]));
   assign prod3 = PROD_W'(stride_ff[2]) * PROD_W'(eff_dim(dim_ff[1]));

   always_comb begin
      stride_in[0] = ADDR_BITS'(eff_dim(dim_ff[0]));
      stride_in[1] = prod1[ADDR_BITS-1:0];
      stride_in[2] = prod2[ADDR_BITS-1:0];
      stride_in[3] = prod3[ADDR_BITS-1:0];
      for (int k = 0; k < NUM_DIMS; k++) begin
         lim_in[k] = CNT_W'(eff_dim(dim_ff[k]) - dim_type'(1));
      end
   end

   always_comb begin
      if (cfg_hit) begin
         busy_in = STRIDE_SETTLE;
      end else if (busy_ff != '0) begin
         busy_in = busy_ff - BUSY_W'(1);
      end else begin
         busy_in = busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
         for (int k = 0; k < NUM_DIMS; k++) begin
            dim_ff[k] <= dim_type'(1);
            lim_ff[k] <= '0;
         end
         for (int k = 0; k < NUM_LEVELS; k++) begin
            stride_ff[k] <= addr_type'(1);
         end
      end else begin
         busy_ff <= busy_in;
         for (int k = 0; k < NUM_DIMS; k++) begin
            dim_ff[k] <= dim_in[k];
            lim_ff[k] <= lim_in[k];
         end
         for (int k = 0; k < NUM_LEVELS; k++) begin
            stride_ff[k] <= stride_in[k];
         end
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_LEVELS; k++) begin
         walk_cfg.stride[k] = stride_ff[k];
      end
      for (int k = 0; k < NUM_DIMS; k++) begin
         walk_cfg.lim[k] = lim_ff[k];
      end
   end

   // An element goes in whenever the skid stage is empty and the strides are settled.
   assign req_ready = room & (busy_ff == '0);
   assign accept    = req_valid & req_ready;

   tasag_walk u_walk (
      .clock    (clock),
      .reset    (reset),
      .clear    (cfg_hit),
      .step     (accept),
      .cfg      (walk_cfg),
      .cur_addr (cur_addr),
      .cur_last (cur_last)
   );

   assign new_beat.value = req_elem_value;
   assign new_beat.addr  = cur_addr;
   assign new_beat.last  = cur_last;

   tasag_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_room   (room),
      .in_beat   (new_beat),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_beat  (rsp_beat)
   );

   assign rsp_out_value    = rsp_beat.value;
   assign rsp_dest_address = rsp_beat.addr;
   assign rsp_last_elem    = rsp_beat.last;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the tensor axis swap address generator.
module tb_top;
   import tasag_pkg::*;

   // Run sizing. The cycle limit is many times the slowest correct run. That run is
   // about 1470 beats, each waiting out a sparse receiver and a sender gap, plus a few
   // dozen register phases and the one long output stall.
   localparam int          RESET_CYCLES  = 5;
   localparam int          RANDOM_BEATS  = 1450;
   localparam int          CSR_SETTLE    = 8;
   localparam int          DRAIN_CYCLES  = 16;
   localparam int          LONG_HOLD     = 300;
   localparam int          HOLD_PHASE    = 0;
   localparam int          HOLD_BEATS    = 200;
   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam logic [63:0] ADDR_MASK     = (64'd1 << ADDR_BITS) - 64'd1;
   localparam dim_type     LARGEST_DIM   = dim_type'(1 << CNT_W);

   // Register indexes past the five dimensions decode to nothing.
   localparam int UNMAPPED_IDX_LO = NUM_DIMS;
   localparam int UNMAPPED_IDX_HI = (1 << (CSR_ADDR_W - 2)) - 1;

   typedef enum logic {ROW_BEAT, ROW_CSR} row_kind_type;
   typedef enum int {PACE_OPEN, PACE_COIN, PACE_SPARSE, PACE_RHYTHM} pace_type;
   typedef enum int {SHAPE_SMALL, SHAPE_WRAP, SHAPE_EXTREME} shape_type;

   // One row of the directed table: either a register write or a source element. The
   // expected address and last flag are typed in only where they are obvious.
   typedef struct {
      row_kind_type   kind;
      int             idx;
      logic [31:0]    data;
      bit             typed;
      addr_type       addr;
      logic           last;
   } plan_row_type;

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_ready;
   logic [DATA_BITS-1:0]  req_elem_value = '0;
   logic                  rsp_valid;
   logic                  rsp_ready      = 1'b0;
   logic [DATA_BITS-1:0]  rsp_out_value;
   logic [ADDR_BITS-1:0]  rsp_dest_address;
   logic                  rsp_last_elem;
   logic                  csr_psel       = 1'b0;
   logic                  csr_penable    = 1'b0;
   logic                  csr_pwrite     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr      = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata     = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   always #2 clock = ~clock;

   tensor_axis_swap_address_gen_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_elem_value   (req_elem_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_value    (rsp_out_value),
      .rsp_dest_address (rsp_dest_address),
      .rsp_last_elem    (rsp_last_elem),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   // ------------------------------------------------------------------------------------
   // Walk predictor. It mirrors the block's own scheme: five index counters, four level
   // bases and a destination pointer, advanced by adding strides. Level base 0 belongs to
   // the outer axis, 1 to swap_second, 2 to between and 3 to swap_first.
   // ------------------------------------------------------------------------------------
   dim_type  dim_reg     [NUM_DIMS];
   cnt_type  walk_idx    [NUM_DIMS];
   addr_type walk_base   [NUM_LEVELS];
   addr_type walk_stride [NUM_LEVELS];
   addr_type walk_ptr;

   // A zero dimension counts as one; anything above 2^20 is clamped to 2^20.
   function automatic dim_type clamp_dim(input dim_type d);
      if (d == '0) return dim_type'(1);
      if (d > LARGEST_DIM) return LARGEST_DIM;
      return d;
   endfunction

   // Destination axis order is inner, swap_second, between, swap_first, outer, so the
   // strides are the running products in that order, all modulo the address space.
   function automatic void reload_strides();
      logic [63:0] run;
      run = 64'(clamp_dim(dim_reg[int'(REG_DIM_INNER)])) & ADDR_MASK;
      walk_stride[0] = addr_type'(run);
      run = (run * 64'(clamp_dim(dim_reg[int'(REG_DIM_SWAP_SECOND)]))) & ADDR_MASK;
      walk_stride[1] = addr_type'(run);
      run = (run * 64'(clamp_dim(dim_reg[int'(REG_DIM_BETWEEN)]))) & ADDR_MASK;
      walk_stride[2] = addr_type'(run);
      run = (run * 64'(clamp_dim(dim_reg[int'(REG_DIM_SWAP_FIRST)]))) & ADDR_MASK;
      walk_stride[3] = addr_type'(run);
   endfunction

   function automatic void restart_walk();
      foreach (walk_idx[k]) walk_idx[k] = '0;
      foreach (walk_base[k]) walk_base[k] = '0;
      walk_ptr = '0;
   endfunction

   // Only the five dimension registers exist. Any write to one of them restarts the walk,
   // while a write elsewhere leaves the traversal where it was.
   function automatic void write_dim_reg(input int idx, input logic [31:0] data);
      if (idx >= NUM_DIMS) return;
      dim_reg[idx] = data[DIM_W-1:0];
      reload_strides();
      restart_walk();
   endfunction

   // Works out the destination beat of one source element and advances the walk. The
   // lowest counter that is not at its limit steps; every counter below it wraps to zero.
   // When a higher level steps, all finer bases are reloaded from its new base.
   function automatic beat_type transpose_step(input logic [DATA_BITS-1:0] v);
      beat_type res;
      cnt_type  lim    [NUM_DIMS];
      logic     at_end [NUM_DIMS];
      logic     all_end;
      addr_type nb;
      int       lvl;
      all_end = 1'b1;
      for (int k = 0; k < NUM_DIMS; k++) begin
         lim[k]    = cnt_type'(clamp_dim(dim_reg[k]) - dim_type'(1));
         at_end[k] = (walk_idx[k] >= lim[k]);
         all_end   = all_end & at_end[k];
      end
      res.value = v;
      res.addr  = walk_ptr;
      res.last  = all_end;
      for (int k = 0; k < NUM_DIMS; k++) begin
         if (!at_end[k]) begin
            walk_idx[k] = walk_idx[k] + cnt_type'(1);
            if (k == 0) begin
               walk_ptr = walk_ptr + addr_type'(1);
            end else begin
               // swap_first steps by stride 2, between by 1, swap_second by 0 and the
               // outer axis by the full product in stride 3.
               lvl = NUM_LEVELS - k;
               nb  = walk_base[lvl] +
                     walk_stride[(k == NUM_DIMS - 1) ? NUM_LEVELS - 1 : NUM_LEVELS - 1 - k];
               for (int j = lvl; j < NUM_LEVELS; j++) walk_base[j] = nb;
               walk_ptr = nb;
            end
            return res;
         end
         walk_idx[k] = '0;
      end
      // The element just predicted closed the tensor; the next one starts a fresh walk.
      restart_walk();
      return res;
   endfunction

   // ------------------------------------------------------------------------------------
   // Result checking. Every accepted result beat is matched, field by field, against the
   // oldest predicted destination beat.
   // ------------------------------------------------------------------------------------
   beat_type    dest_beat_q [$];
   int unsigned fail_count     = 0;
   int unsigned beats_checked  = 0;
   int unsigned tensors_closed = 0;

   always @(posedge clock) begin : rsp_check
      beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (dest_beat_q.size() == 0) begin
            $error("result beat with nothing expected: out_value %h dest_address %h",
                   rsp_out_value, rsp_dest_address);
            fail_count++;
         end else begin
            want = dest_beat_q.pop_front();
            beats_checked++;
            if (want.last) tensors_closed++;
            if (rsp_out_value !== want.value) begin
               $error("out_value: expected %h, got %h", want.value, rsp_out_value);
               fail_count++;
            end
            if (rsp_dest_address !== want.addr) begin
               $error("dest_address: expected %h, got %h", want.addr, rsp_dest_address);
               fail_count++;
            end
            if (rsp_last_elem !== want.last) begin
               $error("last_elem: expected %b, got %b", want.last, rsp_last_elem);
               fail_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------------------
   // Receiver pacing. The result side runs in stretches of its own: always ready, a coin
   // toss, sparse acceptance or a fixed rhythm. Once, on request from the sender, it
   // holds off for a long stretch so the output register and skid stage both fill and
   // the block has to drop req_ready while elements keep being offered.
   // ------------------------------------------------------------------------------------
   bit rsp_hold_req  = 1'b0;
   bit rsp_hold_done = 1'b0;

   initial begin : rsp_pacing
      pace_type pace;
      int       span;
      forever begin
         if (rsp_hold_req && !rsp_hold_done) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_hold_done = 1'b1;
         end else begin
            pace = pace_type'($urandom_range(0, 3));
            span = $urandom_range(4, 40);
            for (int k = 0; k < span; k++) begin
               case (pace)
                  PACE_OPEN:   rsp_ready <= 1'b1;
                  PACE_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
                  PACE_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
                  default:     rsp_ready <= ((k % 5) < 3);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // ------------------------------------------------------------------------------------
   // Sender side. Elements go out in bursts of random length with random gaps between
   // them; some phases run with no gaps at all. A beat is predicted at the edge where it
   // is accepted.
   // ------------------------------------------------------------------------------------
   int unsigned  beats_sent   = 0;
   int unsigned  csr_writes   = 0;
   int           burst_left   = 0;
   bit           no_gaps      = 1'b0;
   plan_row_type directed_plan [$];

   task automatic offer_beat(input logic [DATA_BITS-1:0] v, input bit typed,
                             input addr_type t_addr, input logic t_last);
      beat_type guess;
      int       gap;
      req_valid      <= 1'b1;
      req_elem_value <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      guess = transpose_step(v);
      if (typed) begin
         guess.addr = t_addr;
         guess.last = t_last;
      end
      dest_beat_q.push_back(guess);
      beats_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap        = no_gaps ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Registers change only with nothing in flight: stop offering, let every expected
   // beat come back, then give the pipeline time to settle.
   task automatic quiesce();
      req_valid <= 1'b0;
      while (dest_beat_q.size() != 0) @(posedge clock);
      repeat (CSR_SETTLE) @(posedge clock);
   endtask

   // Setup and access cycle for the write, then a read back of mapped registers, which
   // must return the 21 stored bits. Each call ends with the bus returned to idle.
   task automatic write_csr(input int idx, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * idx);
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      write_dim_reg(idx, data);
      csr_writes++;
      if (idx < NUM_DIMS) begin
         csr_pwrite  <= 1'b0;
         csr_penable <= 1'b0;
         @(posedge clock);
         csr_penable <= 1'b1;
         @(posedge clock);
         while (!csr_pready) @(posedge clock);
         if (csr_prdata !== CSR_DATA_W'(data[DIM_W-1:0])) begin
            $error("prdata of register %0d: expected %h, got %h",
                   idx, CSR_DATA_W'(data[DIM_W-1:0]), csr_prdata);
            fail_count++;
         end
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic void plan_beat(input logic [31:0] v, input bit typed,
                                     input addr_type a, input logic l);
      directed_plan.push_back('{ROW_BEAT, 0, v, typed, a, l});
   endfunction

   function automatic void plan_csr(input int idx, input logic [31:0] data);
      directed_plan.push_back('{ROW_CSR, idx, data, 1'b0, addr_type'(0), 1'b0});
   endfunction

   initial begin : stimulus
      logic [31:0] new_dim [NUM_DIMS];
      logic [31:0] extremes [8];
      logic [31:0] v;
      shape_type   shape;
      int          settings_run;
      int          items;
      int          tensor_size;
      int          split;
      int          pick;
      int          beats_left;
      bit          odd_write;

      settings_run = 0;
      extremes = '{32'h0000_0000, 32'h000F_FFFF, 32'h0010_0000, 32'h0010_0001,
                   32'h001F_FFFF, 32'hFFFF_FFFF, 32'h0020_0000, 32'hFFE0_0001};

      // Predictor starts from the reset state: every dimension one.
      foreach (dim_reg[k]) dim_reg[k] = dim_type'(1);
      reload_strides();
      restart_walk();

      // Directed table. After reset each element is a whole tensor of one, so every
      // beat lands at address zero with the last flag set.
      plan_beat(32'h0000_0000, 1'b1, addr_type'(0), 1'b1);
      plan_beat(32'hFFFF_FFFF, 1'b1, addr_type'(0), 1'b1);
      plan_beat(32'h5A5A_A5A5, 1'b1, addr_type'(0), 1'b1);
      // Inner size two: a two-beat tensor at addresses zero and one.
      plan_csr(REG_DIM_INNER, 32'd2);
      plan_beat(32'h0000_0001, 1'b1, addr_type'(0), 1'b0);
      plan_beat(32'h8000_0000, 1'b1, addr_type'(1), 1'b1);
      // A real swap: both swapped axes of size two, one full tensor.
      plan_csr(REG_DIM_SWAP_FIRST, 32'd2);
      plan_csr(REG_DIM_SWAP_SECOND, 32'd2);
      for (int k = 0; k < 8; k++) plan_beat(32'h0000_0100 + k, 1'b0, addr_type'(0), 1'b0);
      // Oversized, largest, zero and masked-to-zero register values.
      plan_csr(REG_DIM_BETWEEN, 32'hFFFF_FFFF);
      plan_csr(REG_DIM_OUTER, 32'(LARGEST_DIM));
      plan_csr(REG_DIM_INNER, 32'd0);
      plan_csr(REG_DIM_SWAP_FIRST, 32'h0020_0000);
      for (int k = 0; k < 3; k++) plan_beat(32'hC000_0000 + k, 1'b0, addr_type'(0), 1'b0);
      // Writes to unmapped indexes must not disturb the walk in progress.
      plan_csr(UNMAPPED_IDX_LO, 32'd7);
      plan_beat(32'h1234_5678, 1'b0, addr_type'(0), 1'b0);
      plan_beat(32'h8765_4321, 1'b0, addr_type'(0), 1'b0);
      plan_csr(UNMAPPED_IDX_HI, 32'hFFFF_FFFF);
      plan_beat(32'h0F0F_F0F0, 1'b0, addr_type'(0), 1'b0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[r]) begin
         if (directed_plan[r].kind == ROW_CSR) begin
            quiesce();
            write_csr(directed_plan[r].idx, directed_plan[r].data);
         end else begin
            offer_beat(directed_plan[r].data, directed_plan[r].typed,
                       directed_plan[r].addr, directed_plan[r].last);
         end
      end

      // Random phases. Each picks a tensor shape, writes all five dimensions and streams
      // elements. Small shapes close many tensors; the wrap shape drives addresses past
      // 2^20; the extreme shape puts one register at a boundary value.
      while (beats_sent < directed_plan.size() + RANDOM_BEATS) begin
         pick = $urandom_range(0, 9);
         shape = (pick < 6) ? SHAPE_SMALL : (pick < 8) ? SHAPE_WRAP : SHAPE_EXTREME;
         new_dim[int'(REG_DIM_INNER)]       = $urandom_range(1, 4);
         new_dim[int'(REG_DIM_SWAP_FIRST)]  = $urandom_range(1, 4);
         new_dim[int'(REG_DIM_BETWEEN)]     = $urandom_range(1, 3);
         new_dim[int'(REG_DIM_SWAP_SECOND)] = $urandom_range(1, 4);
         new_dim[int'(REG_DIM_OUTER)]       = $urandom_range(1, 3);
         case (shape)
            SHAPE_SMALL: begin
               tensor_size = 1;
               foreach (new_dim[k]) tensor_size = tensor_size * int'(new_dim[k]);
               items = tensor_size * ((tensor_size > 200) ? 1 : $urandom_range(1, 3)) +
                       $urandom_range(0, tensor_size - 1);
               // A size of one may just as well be written as zero.
               foreach (new_dim[k]) begin
                  if (new_dim[k] == 32'd1 && $urandom_range(0, 1) == 1) new_dim[k] = '0;
               end
            end
            SHAPE_WRAP: begin
               new_dim[int'(REG_DIM_INNER)]       = $urandom_range(1, 2);
               new_dim[int'(REG_DIM_SWAP_FIRST)]  = $urandom_range(2, 4);
               new_dim[int'(REG_DIM_BETWEEN)]     = 32'd1;
               new_dim[int'(REG_DIM_SWAP_SECOND)] = ($urandom_range(0, 3) == 0) ?
                                                    $urandom_range(1048577, 2097151) :
                                                    $urandom_range(300000, 1048576);
               items = $urandom_range(30, 80);
            end
            default: begin
               new_dim[$urandom_range(0, NUM_DIMS - 1)] = extremes[$urandom_range(0, 7)];
               items = $urandom_range(20, 60);
            end
         endcase

         quiesce();
         foreach (new_dim[k]) write_csr(k, new_dim[k]);
         no_gaps = ($urandom_range(0, 3) == 0);
         if (settings_run == HOLD_PHASE) begin
            items = HOLD_BEATS;
            rsp_hold_req = 1'b1;
         end
         // The last phase stops at the planned number of beats.
         beats_left = directed_plan.size() + RANDOM_BEATS - int'(beats_sent);
         if (items > beats_left) items = beats_left;
         odd_write = ($urandom_range(0, 3) == 0);
         split = odd_write ? items / 2 : items;

         for (int n = 0; n < items; n++) begin
            if (n == split) begin
               quiesce();
               write_csr($urandom_range(UNMAPPED_IDX_LO, UNMAPPED_IDX_HI), $urandom());
            end
            case ($urandom_range(0, 15))
               0:       v = '0;
               1:       v = '1;
               default: v = $urandom();
            endcase
            offer_beat(v, 1'b0, addr_type'(0), 1'b0);
         end
         settings_run++;
      end

      req_valid <= 1'b0;
      while (dest_beat_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d result beats closing %0d tensors, over %0d random settings",
               beats_checked, tensors_closed, settings_run);
      $display("and %0d register writes, with a %0d-cycle output stall along the way.",
               csr_writes, LONG_HOLD);
      if (fail_count == 0 && dest_beat_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Watchdog: a hung handshake ends the run here.
   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $error("timeout after %0d cycles, %0d beats still expected",
             cycle_count, dest_beat_q.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
